// ----- rtl/core/skv_pkg.sv -----
// Shared types and codes for the sorted key-value table.
package skv_pkg;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_SET    = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_HIT      = 3'd0,
		STAT_MISS     = 3'd1,
		STAT_INSERTED = 3'd2,
		STAT_UPDATED  = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SEARCH_CMP,
		ST_DECIDE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_RESULT
	} state_t;

	localparam int unsigned CMD_BITS      = 2;
	localparam int unsigned KEY_PORT_BITS = 32;
	localparam int unsigned VAL_PORT_BITS = 32;
	localparam int unsigned STATUS_BITS   = 3;
	localparam int unsigned POS_BITS      = 6;
	localparam int unsigned COUNT_BITS    = 7;

endpackage

// ----- rtl/core/sorted_key_value_table.sv -----
// Sorted key-value table: binary search and insert shift over one key/value memory pair.
// Lookup or update: binary search, each probe a read (ST_SEARCH) then a compare (ST_SEARCH_CMP), then ST_DECIDE.
// Insert then moves each later entry up by a read and a write; clear skips the search.
// One request at a time; the next is taken the cycle after a response is loaded.
// The single memory read port sets the pace; a response held by rsp_stall delays the load.
// Reset (arst_n low) empties the table, selects unsigned key order; no clearing pass.
module sorted_key_value_table #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned KEY_BITS   = 32,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic                                  cfg_wr_data,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic [skv_pkg::CMD_BITS-1:0]          cmd,
	input  logic [skv_pkg::KEY_PORT_BITS-1:0]     key,
	input  logic [skv_pkg::VAL_PORT_BITS-1:0]     value,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output logic [skv_pkg::STATUS_BITS-1:0]       status,
	output logic [skv_pkg::POS_BITS-1:0]          position,
	output logic [skv_pkg::VAL_PORT_BITS-1:0]     value_out,
	output logic [skv_pkg::COUNT_BITS-1:0]        entry_count
);
	import skv_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [KEY_BITS-1:0]   key_mem [DEPTH];
	logic [VALUE_BITS-1:0] val_mem [DEPTH];

	state_t state_q, state_d;
	logic   signed_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q, hi_q, mid_q, idx_q;
	logic [CMD_BITS-1:0]   cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [KEY_BITS-1:0]   rd_key_q;
	logic [VALUE_BITS-1:0] rd_val_q;
	status_t               res_status_q;
	logic [CW-1:0]         res_pos_q;
	logic [VALUE_BITS-1:0] res_val_q;
	logic                  rsp_valid_q;
	logic [STATUS_BITS-1:0]   rsp_status_q;
	logic [POS_BITS-1:0]      rsp_pos_q;
	logic [VAL_PORT_BITS-1:0] rsp_val_q;
	logic [COUNT_BITS-1:0]    rsp_count_q;

	logic [CW-1:0]         mid;
	logic [KEY_BITS-1:0]   flip;
	logic                  rd_before;
	logic                  hit;
	logic                  accept;
	logic                  out_free;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic                  wr_key_en;
	logic [AW-1:0]         wr_addr;
	logic [KEY_BITS-1:0]   wr_key;
	logic [VALUE_BITS-1:0] wr_val;

	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign flip      = KEY_BITS'(signed_q) << (KEY_BITS - 1);
	assign rd_before = (rd_key_q ^ flip) < (key_q ^ flip);
	assign hit       = (lo_q < count_q) && (rd_key_q == key_q);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = lo_q[AW-1:0];
		wr_en     = 1'b0;
		wr_key_en = 1'b0;
		wr_addr   = lo_q[AW-1:0];
		wr_key    = key_q;
		wr_val    = val_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (cmd == CMD_CLEAR) ? ST_RESULT : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				rd_en = 1'b1;
				if (lo_q < hi_q) begin
					rd_addr = mid[AW-1:0];
					state_d = ST_SEARCH_CMP;
				end else begin
					rd_addr = lo_q[AW-1:0];
					state_d = ST_DECIDE;
				end
			end
			ST_SEARCH_CMP: begin
				state_d = ST_SEARCH;
			end
			ST_DECIDE: begin
				if (cmd_q == CMD_SET && !hit && count_q < CW'(DEPTH)) begin
					state_d = ST_SHIFT_RD;
				end else begin
					state_d = ST_RESULT;
				end
				if (cmd_q == CMD_SET && hit) begin
					wr_en = 1'b1;
				end
			end
			ST_SHIFT_RD: begin
				if (idx_q > lo_q) begin
					rd_en   = 1'b1;
					rd_addr = AW'(idx_q - CW'(1));
					state_d = ST_SHIFT_WR;
				end else begin
					wr_en     = 1'b1;
					wr_key_en = 1'b1;
					state_d   = ST_RESULT;
				end
			end
			ST_SHIFT_WR: begin
				wr_en     = 1'b1;
				wr_key_en = 1'b1;
				wr_addr   = idx_q[AW-1:0];
				wr_key    = rd_key_q;
				wr_val    = rd_val_q;
				state_d   = ST_SHIFT_RD;
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			val_mem[wr_addr] <= wr_val;
			if (wr_key_en) begin
				key_mem[wr_addr] <= wr_key;
			end
		end
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_q    <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				signed_q <= cfg_wr_data;
			end
			if (accept && cmd == CMD_CLEAR) begin
				count_q <= '0;
			end else if (state_q == ST_SHIFT_RD && !(idx_q > lo_q)) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_RESULT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q        <= cmd;
				key_q        <= KEY_BITS'(key);
				val_q        <= VALUE_BITS'(value);
				lo_q         <= '0;
				hi_q         <= count_q;
				res_status_q <= STAT_HIT;
				res_pos_q    <= '0;
				res_val_q    <= '0;
			end
			ST_SEARCH: begin
				mid_q <= mid;
			end
			ST_SEARCH_CMP: begin
				if (rd_before) begin
					lo_q <= mid_q + CW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			ST_DECIDE: begin
				idx_q <= count_q;
				if (cmd_q == CMD_SET) begin
					if (hit) begin
						res_status_q <= STAT_UPDATED;
						res_pos_q    <= lo_q;
					end else if (count_q >= CW'(DEPTH)) begin
						res_status_q <= STAT_FULL;
					end
				end else if (hit) begin
					res_status_q <= STAT_HIT;
					res_pos_q    <= lo_q;
					res_val_q    <= rd_val_q;
				end else begin
					res_status_q <= STAT_MISS;
				end
			end
			ST_SHIFT_RD: begin
				if (!(idx_q > lo_q)) begin
					res_status_q <= STAT_INSERTED;
					res_pos_q    <= lo_q;
				end
			end
			ST_SHIFT_WR: begin
				idx_q <= idx_q - CW'(1);
			end
			ST_RESULT: begin
				if (out_free) begin
					rsp_status_q <= res_status_q;
					rsp_pos_q    <= POS_BITS'(res_pos_q);
					rsp_val_q    <= VAL_PORT_BITS'(res_val_q);
					rsp_count_q  <= COUNT_BITS'(count_q);
				end
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign position    = rsp_pos_q;
	assign value_out   = rsp_val_q;
	assign entry_count = rsp_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH || state_q == ST_SEARCH_CMP) |-> (lo_q <= hi_q))
		else $error("search window inverted");

	a_shift_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT_WR) |-> (idx_q > lo_q && idx_q < CW'(DEPTH)))
		else $error("shift index out of range");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_SHIFT_RD) |=> $stable(count_q))
		else $error("entry count changed outside clear or insert");

endmodule

// ----- dv/sorted_key_value_table_tb.sv -----
// Testbench for sorted_key_value_table: lookup/set/clear/spare requests checked against a shadow table.
module sorted_key_value_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import skv_pkg::*;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;
	localparam logic [KEY_PORT_BITS-1:0] SIGN_BIT = 32'h8000_0000;

	typedef struct {
		logic [CMD_BITS-1:0]      op;
		logic [KEY_PORT_BITS-1:0] key;
		logic [VAL_PORT_BITS-1:0] value;
	} table_req_t;

	typedef struct {
		status_t                  status;
		logic [POS_BITS-1:0]      position;
		logic [VAL_PORT_BITS-1:0] value_out;
		logic [COUNT_BITS-1:0]    entry_count;
	} table_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [CMD_BITS-1:0] cmd = CMD_LOOKUP;
	logic [KEY_PORT_BITS-1:0] key = '0;
	logic [VAL_PORT_BITS-1:0] value = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [STATUS_BITS-1:0] status;
	logic [POS_BITS-1:0] position;
	logic [VAL_PORT_BITS-1:0] value_out;
	logic [COUNT_BITS-1:0] entry_count;

	table_req_t pending_req[$];
	table_rsp_t expected_rsp[$];
	table_req_t next_req;
	table_rsp_t seen_rsp;

	logic [KEY_PORT_BITS-1:0] shadow_keys[TABLE_DEPTH];
	logic [VAL_PORT_BITS-1:0] shadow_vals[TABLE_DEPTH];
	int shadow_count = 0;
	logic keys_signed = 1'b0;

	logic [KEY_PORT_BITS-1:0] key_pool[80];

	int gap_pct = 0;
	int stall_pct = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_responses = 1'b0;
	int errors = 0;

	sorted_key_value_table uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.key        (key),
		.value      (value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.position   (position),
		.value_out  (value_out),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	function automatic bit key_precedes(logic [KEY_PORT_BITS-1:0] a, logic [KEY_PORT_BITS-1:0] b);
		if (keys_signed)
			return (a ^ SIGN_BIT) < (b ^ SIGN_BIT);
		return a < b;
	endfunction

	function automatic table_rsp_t table_outcome(table_req_t rq);
		table_rsp_t r;
		int lo;
		int hi;
		int mid;
		int i;
		bit found;
		r.status = STAT_MISS;
		r.position = '0;
		r.value_out = '0;
		if (rq.op == CMD_CLEAR) begin
			shadow_count = 0;
			r.status = STAT_HIT;
		end else begin
			lo = 0;
			hi = shadow_count;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (key_precedes(shadow_keys[mid], rq.key))
					lo = mid + 1;
				else
					hi = mid;
			end
			found = (lo < shadow_count) && (shadow_keys[lo] == rq.key);
			if (rq.op == CMD_SET) begin
				if (found) begin
					shadow_vals[lo] = rq.value;
					r.status = STAT_UPDATED;
					r.position = POS_BITS'(lo);
				end else if (shadow_count >= TABLE_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					for (i = shadow_count; i > lo; i--) begin
						shadow_keys[i] = shadow_keys[i-1];
						shadow_vals[i] = shadow_vals[i-1];
					end
					shadow_keys[lo] = rq.key;
					shadow_vals[lo] = rq.value;
					shadow_count++;
					r.status = STAT_INSERTED;
					r.position = POS_BITS'(lo);
				end
			end else if (found) begin
				r.status = STAT_HIT;
				r.position = POS_BITS'(lo);
				r.value_out = shadow_vals[lo];
			end
		end
		r.entry_count = COUNT_BITS'(shadow_count);
		return r;
	endfunction

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			cmd <= CMD_LOOKUP;
			key <= '0;
			value <= '0;
			gap_left = 0;
		end else begin
			if (req_valid && !req_stall)
				expected_rsp.push_back(table_outcome('{cmd, key, value}));
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_req.size() != 0 && $urandom_range(99) < gap_pct) begin
					gap_left = $urandom_range(3, 1) - 1;
					req_valid <= 1'b0;
				end else if (pending_req.size() != 0) begin
					next_req = pending_req.pop_front();
					cmd <= next_req.op;
					key <= next_req.key;
					value <= next_req.value;
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$error("response with no request outstanding: status %0d", status);
					errors++;
				end else begin
					seen_rsp = expected_rsp.pop_front();
					if (status !== seen_rsp.status) begin
						$error("status: expected %0d, got %0d", seen_rsp.status, status);
						errors++;
					end
					if (position !== seen_rsp.position) begin
						$error("position: expected %0d, got %0d", seen_rsp.position, position);
						errors++;
					end
					if (value_out !== seen_rsp.value_out) begin
						$error("value_out: expected %h, got %h", seen_rsp.value_out, value_out);
						errors++;
					end
					if (entry_count !== seen_rsp.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							seen_rsp.entry_count, entry_count);
						errors++;
					end
				end
			end
			if (hold_responses) begin
				hold_responses = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if ($urandom_range(99) < stall_pct) begin
				stall_left = $urandom_range(3, 1) - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic push_req(logic [CMD_BITS-1:0] op, logic [KEY_PORT_BITS-1:0] k,
			logic [VAL_PORT_BITS-1:0] v);
		pending_req.push_back('{op, k, v});
	endtask

	task automatic wait_drained();
		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_key_order(logic mode);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		keys_signed = mode;
		@(negedge clk);
	endtask

	task automatic refresh_pool();
		int i;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h7FFF_FFFF;
		key_pool[3] = 32'h8000_0000;
		for (i = 4; i < $size(key_pool); i++)
			key_pool[i] = $urandom;
	endtask

	task automatic queue_random(int n, int set_pct, int clear_pct);
		int i;
		int r;
		logic [CMD_BITS-1:0] op;
		logic [KEY_PORT_BITS-1:0] k;
		logic [VAL_PORT_BITS-1:0] v;
		refresh_pool();
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < clear_pct)
				op = CMD_CLEAR;
			else if (r < clear_pct + 3)
				op = CMD_SPARE;
			else if (r < clear_pct + 3 + set_pct)
				op = CMD_SET;
			else
				op = CMD_LOOKUP;
			r = $urandom_range(99);
			if (r < 80)
				k = key_pool[$urandom_range($size(key_pool) - 1)];
			else if (r < 90)
				k = $urandom;
			else
				k = key_pool[$urandom_range(3)];
			r = $urandom_range(99);
			if (r < 5)
				v = '0;
			else if (r < 10)
				v = '1;
			else
				v = $urandom;
			push_req(op, k, v);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_key_order(1'b0);
		gap_pct = 20;
		stall_pct = 20;
		push_req(CMD_LOOKUP, 32'h0000_0000, 32'h1111_1111);
		push_req(CMD_SET, 32'h0000_0000, 32'hFFFF_FFFF);
		push_req(CMD_SET, 32'hFFFF_FFFF, 32'h0000_0000);
		push_req(CMD_SET, 32'h8000_0000, 32'h1234_5678);
		push_req(CMD_SET, 32'h7FFF_FFFF, 32'h8765_4321);
		push_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		push_req(CMD_LOOKUP, 32'h0000_0000, 32'h0);
		push_req(CMD_LOOKUP, 32'h0000_0001, 32'h0);
		push_req(CMD_SET, 32'h0000_0000, 32'hA5A5_5A5A);
		push_req(CMD_SPARE, 32'h8000_0000, 32'hFFFF_FFFF);
		push_req(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(CMD_LOOKUP, 32'h0000_0000, 32'h0);
		wait_drained();

		set_key_order(1'b1);
		push_req(CMD_SET, 32'h8000_0000, 32'h0000_0001);
		push_req(CMD_SET, 32'h7FFF_FFFF, 32'h0000_0002);
		push_req(CMD_SET, 32'hFFFF_FFFF, 32'h0000_0003);
		push_req(CMD_SET, 32'h0000_0000, 32'h0000_0004);
		push_req(CMD_SET, 32'h0000_0001, 32'h0000_0005);
		push_req(CMD_LOOKUP, 32'h8000_0000, 32'h0);
		push_req(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0);
		push_req(CMD_SPARE, 32'hFFFF_FFFF, 32'h0);
		push_req(CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0);
		wait_drained();

		// hold responses back with random requests queued behind them
		gap_pct = 25;
		stall_pct = 25;
		hold_responses = 1'b1;
		queue_random(345, 55, 1);
		wait_drained();

		set_key_order(1'b0);
		gap_pct = 50;
		stall_pct = 50;
		queue_random(345, 60, 0);
		wait_drained();

		set_key_order(1'b1);
		gap_pct = 0;
		stall_pct = 0;
		queue_random(345, 45, 2);
		wait_drained();

		set_key_order(1'b0);
		gap_pct = 25;
		stall_pct = 25;
		queue_random(345, 50, 1);
		wait_drained();

		set_key_order(1'b1);
		gap_pct = 0;
		stall_pct = 0;
		queue_random(345, 55, 1);
		wait_drained();

		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
